// File: rtl/core/mrr_pkg.sv
// Package for the Modbus response receiver: shared types, codes and the CRC table.
// No dependencies; used by every module in rtl/core.
package mrr_pkg;

  localparam int REGISTER_COUNT_DEF = 256;
  localparam int MAX_WORDS_DEF      = 123;
  localparam int JOBQ_DEPTH         = 4;

  localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE_MULT = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] WR_QTY_MAX      = 16'd123;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ID   = 2'd0;
  localparam logic [1:0] CFG_READ_START = 2'd1;
  localparam logic [1:0] CFG_WIN_BASE   = 2'd2;
  localparam logic [1:0] CFG_WIN_SPAN   = 2'd3;

  // Frame status codes
  localparam logic [2:0] ST_NO_ID      = 3'd0;
  localparam logic [2:0] ST_READ_DONE  = 3'd1;
  localparam logic [2:0] ST_WRITE_ACK  = 3'd2;
  localparam logic [2:0] ST_CRC_BAD    = 3'd3;
  localparam logic [2:0] ST_RANGE_BAD  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN_FN = 3'd5;

  typedef enum logic [1:0] {FR_HUNT, FR_TAIL1, FR_TAIL2} front_phase_t;
  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_COPY} back_state_t;

  // One job handed from the parser to the back end
  typedef struct packed {
    logic        is_read;
    logic [7:0]  reg_index;
    logic        stg_we;
    logic [6:0]  stg_idx;
    logic [15:0] stg_data;
    logic        is_frame;
    logic        commit;
    logic [2:0]  status;
    logic [6:0]  qty;
    logic [15:0] addr;
  } job_t;

  // One result item
  typedef struct packed {
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [6:0]  words_stored;
    logic        read_valid;
    logic [15:0] reg_data;
  } result_t;

  // Byte-swapped Modbus CRC table entry
  function automatic logic [15:0] crc_entry(input logic [7:0] idx);
    logic [15:0] v;
    v = {8'd0, idx};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// File: rtl/core/mrr_front.sv
// Front end: frame hunting, tail buffer, CRC and field parsing, job generation.
// Depends on mrr_pkg.
module mrr_front import mrr_pkg::*; #(
  parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
  parameter int MAX_WORDS      = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  input  logic [7:0]  reg_index,
  input  logic [7:0]  slave_id,
  input  logic [15:0] read_start,
  input  logic [15:0] win_base,
  input  logic [15:0] win_span,
  output logic        job_push,
  output job_t        job
);

  front_phase_t phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail0_r, tail0_nxt, tail1_r, tail1_nxt;
  logic [7:0]  fc_r, fc_nxt, bc_r, bc_nxt, hold_r, hold_nxt;
  logic [15:0] aa_r, aa_nxt, aq_r, aq_nxt;

  logic [7:0]  k;
  logic [6:0]  q;
  logic [8:0]  need;
  logic [31:0] rd_end;
  logic [16:0] wr_end, win_end;

  // Per-byte parse step; a read command is passed on as a read job instead
  always_comb begin
    phase_nxt = phase_r;  pos_nxt = pos_r;  crc_nxt = crc_r;
    tail0_nxt = tail0_r;  tail1_nxt = tail1_r;
    fc_nxt = fc_r;  bc_nxt = bc_r;  hold_nxt = hold_r;
    aa_nxt = aa_r;  aq_nxt = aq_r;
    job = '0;
    job_push = 1'b0;
    k = pos_r - 8'd3;
    q = bc_nxt[7:1];
    need = 9'd0; rd_end = 32'd0; wr_end = 17'd0; win_end = 17'd0;
    if (take && command) begin
      job.is_read   = 1'b1;
      job.reg_index = reg_index;
      job_push      = 1'b1;
    end else if (take) begin
      if (phase_r == FR_HUNT) begin
        if (rx_byte == slave_id) begin
          pos_nxt = '0; crc_nxt = CRC_INIT; tail0_nxt = '0;
          fc_nxt = '0; bc_nxt = '0; hold_nxt = '0; aa_nxt = '0; aq_nxt = '0;
          tail1_nxt = rx_byte;
          phase_nxt = FR_TAIL1;
        end
      end else begin
        if (phase_r == FR_TAIL2) begin
          // body byte leaving the tail
          crc_nxt = (crc_r << 8) ^ crc_entry(crc_r[15:8] ^ tail0_r);
          if (pos_r == 8'd1) begin
            fc_nxt = tail0_r;
          end else if (pos_r >= 8'd2 && pos_r < 8'd255) begin
            if (fc_r == FUNC_READ_HOLD) begin
              if (pos_r == 8'd2) begin
                bc_nxt = tail0_r;
              end else if (!k[0]) begin
                hold_nxt = tail0_r;
              end else if (32'(k[7:1]) < MAX_WORDS) begin
                job.stg_we   = 1'b1;
                job.stg_idx  = k[7:1];
                job.stg_data = {hold_r, tail0_r};
              end
            end else if (fc_r == FUNC_WRITE_MULT) begin
              case (pos_r)
                8'd2:    aa_nxt[15:8] = tail0_r;
                8'd3:    aa_nxt[7:0]  = tail0_r;
                8'd4:    aq_nxt[15:8] = tail0_r;
                8'd5:    aq_nxt[7:0]  = tail0_r;
                default: ;
              endcase
            end
          end
          if (pos_r != 8'd255) pos_nxt = pos_r + 8'd1;
        end
        tail0_nxt = tail1_r;
        tail1_nxt = rx_byte;
        phase_nxt = FR_TAIL2;
      end
      job_push = job.stg_we;
      // End of frame verdict
      if (end_of_frame) begin
        q = bc_nxt[7:1];
        need = 9'd3 + {1'b0, q, 1'b0};
        rd_end = 32'(read_start) + 32'(q);
        wr_end = {1'b0, aa_nxt} + {1'b0, aq_nxt};
        win_end = {1'b0, win_base} + {1'b0, win_span};
        job.is_frame = 1'b1;
        job.addr = read_start;
        job_push = 1'b1;
        if (phase_nxt == FR_HUNT) begin
          job.status = ST_NO_ID;
        end else if (phase_nxt != FR_TAIL2 || pos_nxt < 8'd1) begin
          job.status = ST_CRC_BAD;
        end else if ({tail0_nxt, tail1_nxt} != crc_nxt) begin
          job.status = ST_CRC_BAD;
        end else if (fc_nxt == FUNC_READ_HOLD) begin
          if (pos_nxt < 8'd3 || q == 7'd0 || 32'(q) > MAX_WORDS ||
              {1'b0, pos_nxt} < need || rd_end > 32'(REGISTER_COUNT)) begin
            job.status = ST_RANGE_BAD;
          end else begin
            job.status = ST_READ_DONE;
            job.commit = 1'b1;
            job.qty    = q;
          end
        end else if (fc_nxt == FUNC_WRITE_MULT) begin
          if (pos_nxt >= 8'd6 && aq_nxt >= 16'd1 && aq_nxt <= WR_QTY_MAX &&
              aa_nxt >= win_base && wr_end <= win_end)
            job.status = ST_WRITE_ACK;
          else
            job.status = ST_RANGE_BAD;
        end else begin
          job.status = ST_UNKNOWN_FN;
        end
        phase_nxt = FR_HUNT;
        pos_nxt = '0; crc_nxt = CRC_INIT; tail0_nxt = '0; tail1_nxt = '0;
        fc_nxt = '0; bc_nxt = '0; hold_nxt = '0; aa_nxt = '0; aq_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= FR_HUNT;  pos_r <= '0;  crc_r <= CRC_INIT;
      tail0_r <= '0;  tail1_r <= '0;  fc_r <= '0;  bc_r <= '0;
      hold_r <= '0;  aa_r <= '0;  aq_r <= '0;
    end else begin
      phase_r <= phase_nxt;  pos_r <= pos_nxt;  crc_r <= crc_nxt;
      tail0_r <= tail0_nxt;  tail1_r <= tail1_nxt;  fc_r <= fc_nxt;
      bc_r <= bc_nxt;  hold_r <= hold_nxt;  aa_r <= aa_nxt;  aq_r <= aq_nxt;
    end
  end

endmodule

// File: rtl/core/mrr_jobq.sv
// Short job queue between the parser and the back end.
// Depends on mrr_pkg.
module mrr_jobq import mrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(JOBQ_DEPTH);

  job_t            mem_r [JOBQ_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW+1)'(JOBQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

// File: rtl/core/mrr_back.sv
// Back end: staging memory, register store, commit copy, reads, result register.
// Depends on mrr_pkg.
module mrr_back import mrr_pkg::*; #(
  parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
  parameter int MAX_WORDS      = MAX_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  job_t    job,
  input  logic    job_avail,
  output logic    job_pop,
  input  logic    res_pop,
  output logic    res_valid,
  output result_t res
);

  localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int SW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [15:0] stg_mem [MAX_WORDS];
  logic [15:0] store_mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] store_vld_r;

  back_state_t st_r, st_nxt;
  logic [6:0]  cnt_r, qty_r, widx_r;
  logic [15:0] addr_r, stg_q_r, store_q_r;
  logic        wv_r, rd_ok_r, out_v_r;
  result_t     res_r, res_nxt;

  logic        rd_issue, load;
  logic [31:0] ridx;
  logic [16:0] waddr;

  assign ridx  = {24'd0, job.reg_index};
  assign waddr = {1'b0, addr_r} + {10'd0, widx_r};
  assign rd_issue = (st_r == BK_COPY) && (cnt_r < qty_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (job_pop) begin
        if (job.is_read)                     st_nxt = BK_READ;
        else if (job.is_frame && job.commit) st_nxt = BK_COPY;
      end
      BK_READ: st_nxt = BK_IDLE;
      BK_COPY: if (!rd_issue && !wv_r) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Controls and result value
  always_comb begin
    job_pop = 1'b0;
    load    = 1'b0;
    res_nxt = '0;
    case (st_r)
      BK_IDLE: begin
        job_pop = job_avail && !out_v_r;
        if (job_pop && job.is_frame && !job.commit) begin
          load = 1'b1;
          res_nxt.frame_done   = 1'b1;
          res_nxt.frame_status = job.status;
        end
      end
      BK_READ: begin
        load = 1'b1;
        res_nxt.read_valid = 1'b1;
        res_nxt.reg_data   = rd_ok_r ? store_q_r : 16'd0;
      end
      BK_COPY: if (!rd_issue && !wv_r) begin
        load = 1'b1;
        res_nxt.frame_done   = 1'b1;
        res_nxt.frame_status = ST_READ_DONE;
        res_nxt.words_stored = qty_r;
      end
      default: ;
    endcase
  end

  // Staging memory
  always_ff @(posedge clk) begin
    if (job_pop && job.stg_we) stg_mem[job.stg_idx[SW-1:0]] <= job.stg_data;
    if (rd_issue) stg_q_r <= stg_mem[cnt_r[SW-1:0]];
  end

  // Register store
  always_ff @(posedge clk) begin
    if (wv_r) store_mem[waddr[AW-1:0]] <= stg_q_r;
    if (job_pop && job.is_read) store_q_r <= store_mem[ridx[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; store_vld_r <= '0; wv_r <= 1'b0; out_v_r <= 1'b0;
      cnt_r <= '0; rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wv_r <= rd_issue;
      if (wv_r) store_vld_r[waddr[AW-1:0]] <= 1'b1;
      if (job_pop && job.is_read)
        rd_ok_r <= (ridx < 32'(REGISTER_COUNT)) && store_vld_r[ridx[AW-1:0]];
      if (job_pop) cnt_r <= '0;
      else if (rd_issue) cnt_r <= cnt_r + 7'd1;
      if (load) out_v_r <= 1'b1;
      else if (res_pop) out_v_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      qty_r  <= job.qty;
      addr_r <= job.addr;
    end
    if (rd_issue) widx_r <= cnt_r;
    if (load) res_r <= res_nxt;
  end

  assign res_valid = out_v_r;
  assign res       = res_r;

endmodule

// File: rtl/core/modbus_response_receiver_top.sv
// Top level of the Modbus response receiver: config registers, front, job queue, back.
// Depends on mrr_pkg, mrr_front, mrr_jobq, mrr_back.
//
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------------------------
//  input    | in_push/in_full | in_command, in_rx_byte, in_end_of_frame, in_reg_index
//  result   | out_empty/out_pop | frame_done, frame_status, words_stored, read_valid, reg_data
//  config   | cfg_we          | cfg_index, cfg_data
//
// A byte is parsed in the cycle it is taken; a result leaves from a one-item register.
// A register read passes through the job queue, a store read at pop, BK_READ and the result
// register; a frame report passes through the job queue and the result register; a committed
// read frame reports after the one-word-per-cycle staging-to-store copy that holds the back end.
// A result holds the back end until popped; no new job is taken while it waits.
// in_full rises while the 4-entry job queue is full; a waiting result holds the back end.
// Synchronous active-low reset; the register store reads as zero until written.
module modbus_response_receiver_top import mrr_pkg::*; #(
  parameter int REGISTER_COUNT      = REGISTER_COUNT_DEF,
  parameter int MAX_WORDS_PER_FRAME = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  input  logic [7:0]  in_reg_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_frame_done,
  output logic [2:0]  out_frame_status,
  output logic [6:0]  out_words_stored,
  output logic        out_read_valid,
  output logic [15:0] out_reg_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  slave_id_r;
  logic [15:0] read_start_r, win_base_r, win_span_r;
  logic        take, job_push, job_pop, q_empty, res_valid;
  job_t        job_in, job_out;
  result_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= 8'd1; read_start_r <= 16'd0;
      win_base_r <= 16'd1000; win_span_r <= 16'd114;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ID:   slave_id_r   <= cfg_data[7:0];
        CFG_READ_START: read_start_r <= cfg_data;
        CFG_WIN_BASE:   win_base_r   <= cfg_data;
        CFG_WIN_SPAN:   win_span_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take = in_push && !in_full;

  mrr_front #(.REGISTER_COUNT(REGISTER_COUNT), .MAX_WORDS(MAX_WORDS_PER_FRAME)) u_front (
    .clk, .rst_n, .take,
    .command(in_command), .rx_byte(in_rx_byte), .end_of_frame(in_end_of_frame),
    .reg_index(in_reg_index), .slave_id(slave_id_r), .read_start(read_start_r),
    .win_base(win_base_r), .win_span(win_span_r), .job_push, .job(job_in)
  );

  mrr_jobq u_jobq (
    .clk, .rst_n, .push(job_push), .din(job_in), .pop(job_pop), .dout(job_out),
    .full(in_full), .empty(q_empty)
  );

  mrr_back #(.REGISTER_COUNT(REGISTER_COUNT), .MAX_WORDS(MAX_WORDS_PER_FRAME)) u_back (
    .clk, .rst_n, .job(job_out), .job_avail(!q_empty), .job_pop,
    .res_pop(out_pop), .res_valid, .res
  );

  assign out_empty        = !res_valid;
  assign out_frame_done   = res.frame_done;
  assign out_frame_status = res.frame_status;
  assign out_words_stored = res.words_stored;
  assign out_read_valid   = res.read_valid;
  assign out_reg_data     = res.reg_data;

  // A result is either a frame report or a read answer, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_frame_done != out_read_valid)) else $error("result kind");

  // Words are reported only on a successful read commit
  a_words: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_words_stored != 7'd0) |-> (out_frame_status == ST_READ_DONE))
    else $error("words without commit");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_reg_data)))
    else $error("result dropped");

endmodule

// File: tb/sv/tb_modbus_response_receiver_top.sv
// Testbench for modbus_response_receiver_top: directed table, then random frames checked by
// a cycle-free predictor of the parser, CRC check, register store and window checks.
// Depends on mrr_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_modbus_response_receiver_top import mrr_pkg::*; ();

  localparam int NREG      = 256;
  localparam int NSTAGE    = 123;
  localparam int LIMIT     = 1500000;
  localparam int SETTLE    = 160;
  localparam int PHASE_LEN = 195;

  typedef struct {
    logic        cmd;
    logic [7:0]  b;
    logic        eof;
    logic [7:0]  idx;
    bit          typed;
    result_t     exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_end_of_frame = 1'b0;
  logic [7:0]  in_reg_index = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_frame_done;
  logic [2:0]  out_frame_status;
  logic [6:0]  out_words_stored;
  logic        out_read_valid;
  logic [15:0] out_reg_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SLAVE_ID;
  logic [15:0] cfg_data = 16'h0000;

  modbus_response_receiver_top uut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and configuration
  logic [7:0]   p_sid;
  logic [15:0]  p_rstart, p_wbase, p_wspan;
  front_phase_t p_phase;
  logic [7:0]   p_pos, p_fn, p_bcnt, p_hold;
  logic [15:0]  p_crc, p_aaddr, p_aqty;
  logic [7:0]   p_tail [2];
  logic [15:0]  p_stage [NSTAGE];
  logic [15:0]  p_store [NREG];

  result_t     expected_results [$];
  stim_row_t   directed [$];
  stim_row_t   frame_items [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  bit          cur_typed = 1'b0;
  result_t     cur_exp;

  // Modbus CRC step in the byte-swapped form
  function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = {8'h00, c[15:8] ^ b};
    repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    return {c[7:0], 8'h00} ^ {v[7:0], v[15:8]};
  endfunction

  task automatic clear_frame_state();
    p_pos = 8'd0; p_crc = CRC_INIT; p_tail[0] = 8'd0; p_tail[1] = 8'd0;
    p_fn = 8'd0; p_bcnt = 8'd0; p_aaddr = 16'd0; p_aqty = 16'd0; p_hold = 8'd0;
  endtask

  task automatic absorb_body_byte(logic [7:0] b);
    int k;
    k = int'(p_pos) - 3;
    p_crc = crc_fold(p_crc, b);
    if (p_pos == 8'd1) p_fn = b;
    else if (p_pos >= 8'd2 && p_pos < 8'd255) begin
      if (p_fn == FUNC_READ_HOLD) begin
        if (p_pos == 8'd2) p_bcnt = b;
        else if (k % 2 == 0) p_hold = b;
        else if (k / 2 < NSTAGE) p_stage[k / 2] = {p_hold, b};
      end else if (p_fn == FUNC_WRITE_MULT) begin
        case (p_pos)
          8'd2: p_aaddr[15:8] = b;
          8'd3: p_aaddr[7:0] = b;
          8'd4: p_aqty[15:8] = b;
          8'd5: p_aqty[7:0] = b;
          default: ;
        endcase
      end
    end
    if (p_pos != 8'd255) p_pos = p_pos + 8'd1;
  endtask

  // status and committed count of a finished frame
  task automatic close_frame(output logic [2:0] st, output logic [6:0] nw);
    int q;
    int a;
    nw = 7'd0;
    if (p_phase != FR_TAIL2 || p_pos < 8'd1 || {p_tail[0], p_tail[1]} != p_crc) begin
      st = ST_CRC_BAD;
    end else if (p_fn == FUNC_READ_HOLD) begin
      q = int'(p_bcnt) / 2;
      a = int'(p_rstart);
      if (p_pos < 8'd3 || q < 1 || q > NSTAGE || int'(p_pos) < 3 + 2 * q || a + q > NREG) begin
        st = ST_RANGE_BAD;
      end else begin
        for (int i = 0; i < q; i++) p_store[a + i] = p_stage[i];
        st = ST_READ_DONE;
        nw = q[6:0];
      end
    end else if (p_fn == FUNC_WRITE_MULT) begin
      if (p_pos >= 8'd6 && p_aqty >= 16'd1 && p_aqty <= WR_QTY_MAX &&
          p_aaddr >= p_wbase &&
          int'(p_aaddr) + int'(p_aqty) <= int'(p_wbase) + int'(p_wspan))
        st = ST_WRITE_ACK;
      else
        st = ST_RANGE_BAD;
    end else begin
      st = ST_UNKNOWN_FN;
    end
  endtask

  // one accepted item into the predictor; returns whether it causes a result
  task automatic predict_item(logic cmd, logic [7:0] b, logic eof, logic [7:0] idx,
                              output bit has, output result_t r);
    logic [2:0] st;
    logic [6:0] nw;
    r = '0;
    has = 1'b0;
    if (cmd) begin
      r.read_valid = 1'b1;
      r.reg_data = p_store[idx];
      has = 1'b1;
    end else begin
      if (p_phase == FR_HUNT) begin
        if (b == p_sid) begin
          clear_frame_state();
          p_tail[1] = b;
          p_phase = FR_TAIL1;
        end
      end else begin
        if (p_phase == FR_TAIL2) absorb_body_byte(p_tail[0]);
        p_tail[0] = p_tail[1];
        p_tail[1] = b;
        p_phase = FR_TAIL2;
      end
      if (eof) begin
        if (p_phase == FR_HUNT) begin
          st = ST_NO_ID;
          nw = 7'd0;
        end else begin
          close_frame(st, nw);
        end
        p_phase = FR_HUNT;
        clear_frame_state();
        r.frame_done = 1'b1;
        r.frame_status = st;
        r.words_stored = nw;
        has = 1'b1;
      end
    end
  endtask

  // input monitor: config writes and accepted items feed the predictor
  always @(posedge clk) begin
    bit      has;
    result_t r;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ID:   p_sid = cfg_data[7:0];
          CFG_READ_START: p_rstart = cfg_data;
          CFG_WIN_BASE:   p_wbase = cfg_data;
          default:        p_wspan = cfg_data;
        endcase
      end
      if (in_push && !in_full) begin
        predict_item(in_command, in_rx_byte, in_end_of_frame, in_reg_index, has, r);
        if (cur_typed) expected_results.push_back(cur_exp);
        else if (has) expected_results.push_back(r);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        e = expected_results.pop_front();
        if (out_frame_done !== e.frame_done || out_frame_status !== e.frame_status ||
            out_words_stored !== e.words_stored || out_read_valid !== e.read_valid ||
            out_reg_data !== e.reg_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp done=%0d st=%0d n=%0d rv=%0d d=%h, got %0d %0d %0d %0d %h",
                     cycles, e.frame_done, e.frame_status, e.words_stored, e.read_valid,
                     e.reg_data, out_frame_done, out_frame_status, out_words_stored,
                     out_read_valid, out_reg_data);
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_req <= hold_req - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL modbus_response_receiver_top");
      $finish;
    end
  end

  // offer one item until taken
  task automatic send_item(stim_row_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    cur_typed = s.typed;
    cur_exp = s.exp;
    in_push <= 1'b1;
    in_command <= s.cmd;
    in_rx_byte <= s.b;
    in_end_of_frame <= s.eof;
    in_reg_index <= s.idx;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_results.size() != 0 || hold_req != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] sid, logic [15:0] rs, logic [15:0] wb,
                            logic [15:0] ws);
    @(negedge clk); cfg_we <= 1'b1; cfg_index <= CFG_SLAVE_ID;   cfg_data <= {8'h00, sid};
    @(negedge clk);                 cfg_index <= CFG_READ_START; cfg_data <= rs;
    @(negedge clk);                 cfg_index <= CFG_WIN_BASE;   cfg_data <= wb;
    @(negedge clk);                 cfg_index <= CFG_WIN_SPAN;   cfg_data <= ws;
    @(negedge clk); cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t row(logic cmd, logic [7:0] b, logic eof, logic [7:0] idx);
    stim_row_t s;
    s.cmd = cmd; s.b = b; s.eof = eof; s.idx = idx; s.typed = 1'b0; s.exp = '0;
    return s;
  endfunction

  // bytes of a frame with its CRC appended; the last byte carries the end mark
  task automatic build_frame(logic [7:0] body [$], bit bad_crc, int drop_tail,
                             ref stim_row_t q [$]);
    logic [15:0] c;
    logic [7:0]  all [$];
    c = CRC_INIT;
    foreach (body[i]) c = crc_fold(c, body[i]);
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
    all = body;
    all.push_back(c[15:8]);
    all.push_back(c[7:0]);
    repeat (drop_tail) if (all.size() > 1) void'(all.pop_back());
    foreach (all[i]) begin
      if ($urandom_range(99) < 8) q.push_back(row(1'b1, 8'($urandom), 1'b0, 8'($urandom)));
      q.push_back(row(1'b0, all[i], i == all.size() - 1, 8'($urandom)));
    end
  endtask

  // random frame, mostly well formed
  task automatic make_random_frame(ref stim_row_t q [$]);
    logic [7:0] body [$];
    int kind, n, a, wq;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 30)
      q.push_back(row(1'b0, 8'($urandom), $urandom_range(9) == 0, 8'($urandom)));
    body.push_back(p_sid);
    if (kind < 45) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8);
      body.push_back(FUNC_READ_HOLD);
      body.push_back(($urandom_range(19) == 0) ? 8'($urandom) : 8'(2 * n));
      if ($urandom_range(39) == 0) n = n + 4;
      repeat (2 * n) body.push_back(8'($urandom));
    end else if (kind < 75) begin
      a = int'(p_wbase) + $urandom_range(int'(p_wspan) + 4) - 2;
      wq = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
      body.push_back(FUNC_WRITE_MULT);
      body.push_back(a[15:8]); body.push_back(a[7:0]);
      body.push_back(wq[15:8]); body.push_back(wq[7:0]);
      if ($urandom_range(9) == 0) void'(body.pop_back());
    end else if (kind < 85) begin
      body.push_back(8'($urandom));
      repeat ($urandom_range(4)) body.push_back(8'($urandom));
    end else if (kind < 88) begin
      body.push_back(8'($urandom));
      repeat (255 + $urandom_range(8)) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(3)) body.push_back(8'($urandom));
    end
    build_frame(body, $urandom_range(99) < 10, ($urandom_range(99) < 5) ? $urandom_range(3) : 0, q);
    repeat ($urandom_range(2)) q.push_back(row(1'b1, 8'($urandom), 1'b0, 8'($urandom)));
  endtask

  initial begin
    stim_row_t  s;
    logic [7:0] body [$];
    int         sent;
    int         ph;
    logic [15:0] settings [6][4] = '{
      '{16'd1,    16'd0,     16'd1000,  16'd114},
      '{16'd0,    16'd0,     16'd0,     16'd1},
      '{16'd255,  16'd250,   16'd65535, 16'd65535},
      '{16'd17,   16'd65535, 16'd0,     16'd65535},
      '{16'hA5,   16'd128,   16'd1000,  16'd114},
      '{16'd1,    16'd0,     16'd65530, 16'd3}};
    int idle_mode [6][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{26, 26}, '{0, 0}, '{26, 26}};

    // reset state of the predictor
    p_sid = 8'd1; p_rstart = 16'd0; p_wbase = 16'd1000; p_wspan = 16'd114;
    p_phase = FR_HUNT;
    clear_frame_state();
    foreach (p_stage[i]) p_stage[i] = 16'd0;
    foreach (p_store[i]) p_store[i] = 16'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reads after reset, end mark while hunting, short frames
    s = row(1'b1, 8'hFF, 1'b0, 8'd0);   s.typed = 1'b1; s.exp.read_valid = 1'b1;
    directed.push_back(s);
    s = row(1'b1, 8'h00, 1'b1, 8'd255); s.typed = 1'b1; s.exp.read_valid = 1'b1;
    directed.push_back(s);
    s = row(1'b0, 8'h00, 1'b1, 8'd0);   s.typed = 1'b1; s.exp.frame_done = 1'b1;
    s.exp.frame_status = ST_NO_ID; directed.push_back(s);
    s = row(1'b0, 8'h01, 1'b1, 8'hFF);  s.typed = 1'b1; s.exp.frame_done = 1'b1;
    s.exp.frame_status = ST_CRC_BAD; directed.push_back(s);
    directed.push_back(row(1'b0, 8'h01, 1'b0, 8'd0));
    s = row(1'b0, 8'hFF, 1'b1, 8'd0);   s.typed = 1'b1; s.exp.frame_done = 1'b1;
    s.exp.frame_status = ST_CRC_BAD; directed.push_back(s);
    // good read response of one word, then read it back
    body = '{8'h01, FUNC_READ_HOLD, 8'h02, 8'hBE, 8'hEF};
    build_frame(body, 0, 0, directed);
    directed.push_back(row(1'b1, 8'h00, 1'b0, 8'd0));
    // write response at the window base that runs past the window end, unknown function, bad CRC
    body = '{8'h01, FUNC_WRITE_MULT, 8'h03, 8'hE8, 8'h00, 8'h7B};
    build_frame(body, 0, 0, directed);
    body = '{8'h01, 8'h07};
    build_frame(body, 0, 0, directed);
    body = '{8'h01, FUNC_READ_HOLD, 8'h02, 8'h12, 8'h34};
    build_frame(body, 1, 0, directed);
    foreach (directed[i]) send_item(directed[i]);
    cur_typed = 1'b0;
    drain();

    // random phases, each with its own settings and idling
    for (ph = 0; ph < 6; ph++) begin
      write_regs(settings[ph][0][7:0], settings[ph][1], settings[ph][2], settings[ph][3]);
      repeat (2) @(posedge clk);
      send_idle_pct = idle_mode[ph][0];
      recv_stall_pct = idle_mode[ph][1];
      if (ph == 2) hold_req = 3000;
      sent = 0;
      while (sent < PHASE_LEN) begin
        frame_items.delete();
        make_random_frame(frame_items);
        foreach (frame_items[i]) send_item(frame_items[i]);
        sent += frame_items.size();
      end
      // make sure no frame is left open across the register writes
      send_item(row(1'b0, 8'($urandom), 1'b1, 8'($urandom)));
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS modbus_response_receiver_top");
    end else begin
      $display("FAIL modbus_response_receiver_top");
    end
    $finish;
  end

endmodule
